>>> src/bmie_pkg.sv
package bmie_pkg;

	// Item kinds carried on the opcode field
	localparam logic [1:0] ITEM_EXEC   = 2'd0;
	localparam logic [1:0] ITEM_LDREG  = 2'd1;
	localparam logic [1:0] ITEM_LDMEM  = 2'd2;

	// Syscall numbers
	localparam logic [7:0] SYS_READ_A    = 8'd1;
	localparam logic [7:0] SYS_PRINT_NUM = 8'd2;
	localparam logic [7:0] SYS_READ_B    = 8'd3;
	localparam logic [7:0] SYS_PRINT_CHR = 8'd4;

	localparam int unsigned DATA_DEPTH = 256;
	localparam int unsigned NUM_REGS   = 16;

	// Instruction major opcodes (bits 15-12)
	typedef enum logic [3:0] {
		OP_DIVPUSH  = 4'd0,
		OP_POPRET   = 4'd1,
		OP_SLT_SHL  = 4'd2,
		OP_SUB_SHR  = 4'd3,
		OP_LD_ADD   = 4'd4,
		OP_ST_OR    = 4'd5,
		OP_MUL_AND  = 4'd6,
		OP_JIND_XOR = 4'd7,
		OP_JZ       = 4'd8,
		OP_JNZ      = 4'd9,
		OP_JAL      = 4'd10,
		OP_CALL     = 4'd11,
		OP_LDK      = 4'd12,
		OP_STK      = 4'd13,
		OP_LI       = 4'd14,
		OP_SYS      = 4'd15
	} op_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RDA,
		S_MEM,
		S_CALC,
		S_ITER,
		S_WR1,
		S_WR2,
		S_DONE
	} state_t;

endpackage

>>> src/byte_machine_instruction_executor.sv
// Execute unit of a small byte machine: sixteen 8-bit registers, 256 bytes of data memory
// and an 8-bit program counter. Each item on the input channel is one instruction word
// (fetched by the user at the last reported next_pc) or a preload of a register or memory
// byte; each item produces exactly one result beat. After reset the block runs a clearing
// pass over the data memory and register file with item_stall high; start_pc
// writes are taken at any time. The work of an item runs one step at a time through a single
// shared 9-bit adder, a register file with two read ports and one write port, and a single-port
// data memory; a multiply or a divide by a nonzero value runs eight shift-and-add or
// restoring steps that reuse that adder. The next item is accepted the cycle after the result
// is loaded, even while that result beat is still stalled.
module byte_machine_instruction_executor
	import bmie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        start_pc_we,
	input  logic [7:0]  start_pc,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] instruction,
	input  logic [7:0]  in_value,
	input  logic        in_present,
	input  logic [7:0]  load_address,
	input  logic [7:0]  load_value,

	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  next_pc,
	output logic        out_valid,
	output logic        out_kind,
	output logic [7:0]  out_value,
	output logic        in_taken,
	output logic        halted,
	output logic [7:0]  exit_code
);

	// Storage
	logic [7:0] rf_mem [NUM_REGS];
	logic [7:0] data_mem [DATA_DEPTH];

	state_t state_q, state_d;

	logic [7:0] clr_cnt_q;
	logic [2:0] it_cnt_q;
	logic       itmul_q;

	// Latched item
	logic [1:0] item_q;
	op_t        opc_q;
	logic [3:0] a_q, b_q, c_q;
	logic [7:0] in_value_q;
	logic       in_present_q;
	logic [7:0] laddr_q, lval_q;

	// Operands and machine state
	logic [7:0] rd0_q, rd1_q;
	logic [7:0] ra_q, rb_q, rc_q;
	logic [7:0] md_q;
	logic [7:0] pc_q;
	logic       halt_q;
	logic [7:0] exit_q;
	logic [7:0] rem_q, quo_q;

	// Pending register writes
	logic       w1_en_q, w2_en_q;
	logic [3:0] w1_addr_q, w2_addr_q;
	logic [7:0] w1_data_q, w2_data_q;

	// Print / read flags of the current item
	logic       ov_q, ok_q, taken_q;
	logic [7:0] oval_q;

	// Result register
	logic       res_valid_q;
	logic [7:0] res_pc_q, res_oval_q, res_exit_q;
	logic       res_ov_q, res_ok_q, res_taken_q, res_halt_q;

	logic       accept, res_load, exe, b_ne_c, b_le_c, a_ne_b, a_ne_c;
	logic [3:0] nx;
	logic [7:0] k;

	// Shared adder
	logic [8:0] add_a, add_b;
	logic       add_inv, add_cin;
	logic [9:0] add_sum;

	// Iteration step results
	logic [7:0] it_rem_d, it_quo_d;

	// Port controls
	logic       rf_we;
	logic [3:0] rf_waddr, rd_addr0, rd_addr1;
	logic [7:0] rf_wdata;
	logic       mem_we;
	logic [7:0] mem_addr, mem_wdata;

	// Outcome of the execute step
	logic       calc_w1_en, calc_w2_en, calc_pc_en, calc_halt, calc_iter;
	logic [3:0] calc_w1_addr, calc_w2_addr;
	logic [7:0] calc_w1_data, calc_w2_data, calc_pc;
	logic       calc_ov, calc_ok, calc_taken;

	assign accept   = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign res_load = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	assign exe    = (item_q == ITEM_EXEC) && !halt_q;
	assign b_ne_c = (b_q != c_q);
	assign b_le_c = (b_q <= c_q);
	assign a_ne_b = (a_q != b_q);
	assign a_ne_c = (a_q != c_q);
	assign nx     = a_q + 4'd1;
	assign k      = {b_q, c_q};

	assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {9{add_inv}}} + {9'd0, add_cin};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == 8'hFF) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_RDA;
				end
			end
			S_RDA: state_d = S_MEM;
			S_MEM: state_d = S_CALC;
			S_CALC: begin
				if (calc_iter) begin
					state_d = S_ITER;
				end else if (calc_w1_en) begin
					state_d = S_WR1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_ITER: begin
				if (it_cnt_q == 3'd7) begin
					state_d = S_WR1;
				end
			end
			S_WR1: state_d = w2_en_q ? S_WR2 : S_DONE;
			S_WR2: state_d = S_DONE;
			S_DONE: begin
				if (res_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Steer the shared adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_inv = 1'b0;
		add_cin = 1'b0;
		unique case (state_q)
			S_MEM: begin
				unique case (opc_q)
					OP_DIVPUSH, OP_CALL: begin
						add_a = {1'b0, rd0_q};
						add_b = 9'h0FF;
					end
					OP_JIND_XOR: begin
						add_a = {1'b0, rd0_q};
						add_b = {1'b0, rb_q};
					end
					default: begin
						add_a = {1'b0, rb_q};
						add_b = {1'b0, rc_q};
					end
				endcase
			end
			S_CALC: begin
				unique case (opc_q)
					OP_DIVPUSH, OP_CALL: begin
						add_a = {1'b0, ra_q};
						add_b = 9'h0FF;
					end
					OP_POPRET: begin
						add_a   = {1'b0, ra_q};
						add_b   = a_ne_c ? {1'b0, rc_q} : 9'd0;
						add_cin = 1'b1;
					end
					OP_SLT_SHL, OP_SUB_SHR: begin
						add_a   = {1'b0, rb_q};
						add_b   = {1'b0, rc_q};
						add_inv = 1'b1;
						add_cin = 1'b1;
					end
					default: begin
						add_a = {1'b0, rb_q};
						add_b = {1'b0, rc_q};
					end
				endcase
			end
			S_ITER: begin
				if (itmul_q) begin
					add_a = {1'b0, rem_q};
					add_b = quo_q[0] ? {1'b0, rc_q} : 9'd0;
				end else begin
					add_a   = {rem_q, quo_q[7]};
					add_b   = {1'b0, rc_q};
					add_inv = 1'b1;
					add_cin = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// One multiply or divide step
	always_comb begin
		if (itmul_q) begin
			it_rem_d = add_sum[8:1];
			it_quo_d = {add_sum[0], quo_q[7:1]};
		end else begin
			it_rem_d = add_sum[9] ? add_sum[7:0] : {rem_q[6:0], quo_q[7]};
			it_quo_d = {quo_q[6:0], add_sum[9]};
		end
	end

	// Execute step: register writes, jumps, halt and syscall effects
	always_comb begin
		calc_w1_en   = 1'b0;
		calc_w1_addr = a_q;
		calc_w1_data = '0;
		calc_w2_en   = 1'b0;
		calc_w2_addr = a_q;
		calc_w2_data = '0;
		calc_pc_en   = 1'b0;
		calc_pc      = k;
		calc_halt    = 1'b0;
		calc_iter    = 1'b0;
		calc_ov      = 1'b0;
		calc_ok      = 1'b0;
		calc_taken   = 1'b0;
		if (item_q == ITEM_LDREG) begin
			calc_w1_en   = 1'b1;
			calc_w1_addr = laddr_q[3:0];
			calc_w1_data = lval_q;
		end else if (exe) begin
			unique case (opc_q)
				OP_DIVPUSH: begin
					if (b_ne_c) begin
						calc_iter = (rc_q != 8'd0);
					end else if (a_ne_b) begin
						calc_w1_en   = 1'b1;
						calc_w1_data = add_sum[7:0];
					end else begin
						calc_halt = 1'b1;
					end
				end
				OP_POPRET: begin
					if (a_ne_b && a_ne_c) begin
						calc_pc_en   = 1'b1;
						calc_pc      = md_q;
						calc_w1_en   = 1'b1;
						calc_w1_data = add_sum[7:0];
						calc_w2_en   = 1'b1;
						calc_w2_addr = b_q;
						calc_w2_data = pc_q;
					end else if (a_ne_b) begin
						calc_w1_en   = 1'b1;
						calc_w1_addr = b_q;
						calc_w1_data = md_q;
						calc_w2_en   = 1'b1;
						calc_w2_data = add_sum[7:0];
					end else begin
						calc_pc_en   = 1'b1;
						calc_pc      = rc_q;
						calc_w1_en   = 1'b1;
						calc_w1_data = pc_q;
					end
				end
				OP_SLT_SHL: begin
					calc_w1_en   = 1'b1;
					calc_w1_data = b_ne_c ? {7'd0, !add_sum[9]} : {rb_q[6:0], 1'b0};
				end
				OP_SUB_SHR: begin
					calc_w1_en   = 1'b1;
					calc_w1_data = b_ne_c ? add_sum[7:0] : {1'b0, rb_q[7:1]};
				end
				OP_LD_ADD: begin
					calc_w1_en   = 1'b1;
					calc_w1_data = b_le_c ? md_q : add_sum[7:0];
				end
				OP_ST_OR: begin
					calc_w1_en   = !b_le_c;
					calc_w1_data = rb_q | rc_q;
				end
				OP_MUL_AND: begin
					calc_iter    = b_le_c;
					calc_w1_en   = !b_le_c;
					calc_w1_data = rb_q & rc_q;
				end
				OP_JIND_XOR: begin
					calc_w1_en = 1'b1;
					if (b_le_c) begin
						calc_pc_en   = 1'b1;
						calc_pc      = md_q;
						calc_w1_data = pc_q;
					end else begin
						calc_w1_data = rb_q ^ rc_q;
					end
				end
				OP_JZ:  calc_pc_en = (ra_q == 8'd0);
				OP_JNZ: calc_pc_en = (ra_q != 8'd0);
				OP_JAL: begin
					calc_pc_en   = 1'b1;
					calc_w1_en   = 1'b1;
					calc_w1_data = pc_q;
				end
				OP_CALL: begin
					calc_pc_en   = 1'b1;
					calc_w1_en   = 1'b1;
					calc_w1_data = add_sum[7:0];
				end
				OP_LDK: begin
					calc_w1_en   = 1'b1;
					calc_w1_data = md_q;
				end
				OP_STK: ;
				OP_LI: begin
					calc_w1_en   = 1'b1;
					calc_w1_data = k;
				end
				OP_SYS: begin
					if (k == SYS_READ_A || k == SYS_READ_B) begin
						calc_w1_en   = 1'b1;
						calc_w1_addr = nx;
						calc_w1_data = {7'd0, in_present_q};
						calc_w2_en   = in_present_q;
						calc_w2_data = in_value_q;
						calc_taken   = in_present_q;
					end else if (k == SYS_PRINT_NUM || k == SYS_PRINT_CHR) begin
						calc_ov = 1'b1;
						calc_ok = (k == SYS_PRINT_CHR);
					end
				end
				default: ;
			endcase
		end
	end

	// Data memory port: clearing pass, preload or instruction access
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = add_sum[7:0];
		mem_wdata = rd0_q;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_addr  = clr_cnt_q;
			mem_wdata = '0;
		end else if (state_q == S_MEM) begin
			if (item_q == ITEM_LDMEM) begin
				mem_we    = 1'b1;
				mem_addr  = laddr_q;
				mem_wdata = lval_q;
			end else if (exe) begin
				unique case (opc_q)
					OP_DIVPUSH: begin
						mem_we    = !b_ne_c && a_ne_b;
						mem_wdata = rb_q;
					end
					OP_POPRET: mem_addr = rd0_q;
					OP_ST_OR:  mem_we = b_le_c;
					OP_CALL: begin
						mem_we    = 1'b1;
						mem_wdata = pc_q;
					end
					OP_LDK: mem_addr = k;
					OP_STK: begin
						mem_we   = 1'b1;
						mem_addr = k;
					end
					default: ;
				endcase
			end
		end
	end

	// Register file ports
	always_comb begin
		rd_addr0 = (state_q == S_IDLE) ? instruction[7:4] : a_q;
		rd_addr1 = (state_q == S_IDLE) ? instruction[3:0] : c_q;
		rf_we    = 1'b0;
		rf_waddr = w1_addr_q;
		rf_wdata = w1_data_q;
		unique case (state_q)
			S_CLEAR: begin
				rf_we    = (clr_cnt_q[7:4] == 4'd0);
				rf_waddr = clr_cnt_q[3:0];
				rf_wdata = '0;
			end
			S_WR1: rf_we = w1_en_q;
			S_WR2: begin
				rf_we    = w2_en_q;
				rf_waddr = w2_addr_q;
				rf_wdata = w2_data_q;
			end
			default: ;
		endcase
	end

	// Data memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			data_mem[mem_addr] <= mem_wdata;
		end
		md_q <= data_mem[mem_addr];
	end

	// Register file with two registered reads
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_waddr] <= rf_wdata;
		end
		rd0_q <= rf_mem[rd_addr0];
		rd1_q <= rf_mem[rd_addr1];
	end

	// Capture the item and its operands
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q       <= opcode;
			opc_q        <= op_t'(instruction[15:12]);
			a_q          <= instruction[11:8];
			b_q          <= instruction[7:4];
			c_q          <= instruction[3:0];
			in_value_q   <= in_value;
			in_present_q <= in_present;
			laddr_q      <= load_address;
			lval_q       <= load_value;
		end
		if (state_q == S_RDA) begin
			rb_q <= rd0_q;
			rc_q <= rd1_q;
		end
		if (state_q == S_MEM) begin
			ra_q <= rd0_q;
		end
		if (state_q == S_CALC) begin
			oval_q <= ra_q;
		end
		// seed or advance the shared multiply / divide iteration
		if (state_q == S_CALC) begin
			rem_q <= '0;
			quo_q <= rb_q;
		end else if (state_q == S_ITER) begin
			rem_q <= it_rem_d;
			quo_q <= it_quo_d;
		end
	end

	// Sequencer counters, pending writes and machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			it_cnt_q  <= '0;
			itmul_q   <= 1'b0;
			pc_q      <= '0;
			halt_q    <= 1'b0;
			exit_q    <= '0;
			w1_en_q   <= 1'b0;
			w2_en_q   <= 1'b0;
			w1_addr_q <= '0;
			w2_addr_q <= '0;
			w1_data_q <= '0;
			w2_data_q <= '0;
			ov_q      <= 1'b0;
			ok_q      <= 1'b0;
			taken_q   <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 8'd1;
			end
			// advance pc before execute
			if (state_q == S_RDA && exe) begin
				pc_q <= pc_q + 8'd1;
			end
			if (state_q == S_CALC) begin
				w1_en_q   <= calc_w1_en;
				w1_addr_q <= calc_w1_addr;
				w1_data_q <= calc_w1_data;
				w2_en_q   <= calc_w2_en;
				w2_addr_q <= calc_w2_addr;
				w2_data_q <= calc_w2_data;
				ov_q      <= calc_ov;
				ok_q      <= calc_ok;
				taken_q   <= calc_taken;
				it_cnt_q  <= '0;
				itmul_q   <= (opc_q == OP_MUL_AND);
				if (calc_pc_en) begin
					pc_q <= calc_pc;
				end
				if (calc_halt) begin
					halt_q <= 1'b1;
					exit_q <= ra_q;
				end
			end
			// last step: queue quotient/remainder or low/high product
			if (state_q == S_ITER) begin
				it_cnt_q <= it_cnt_q + 3'd1;
				if (it_cnt_q == 3'd7) begin
					w1_en_q   <= 1'b1;
					w2_en_q   <= 1'b1;
					w1_addr_q <= itmul_q ? nx : a_q;
					w1_data_q <= itmul_q ? it_rem_d : it_quo_d;
					w2_addr_q <= itmul_q ? a_q : nx;
					w2_data_q <= itmul_q ? it_quo_d : it_rem_d;
				end
			end
			if (start_pc_we) begin
				pc_q <= start_pc;
			end
		end
	end

	// Result register: load when free, drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_pc_q    <= pc_q;
			res_ov_q    <= ov_q;
			res_ok_q    <= ok_q;
			res_oval_q  <= ov_q ? oval_q : 8'd0;
			res_taken_q <= taken_q;
			res_halt_q  <= halt_q;
			res_exit_q  <= exit_q;
		end
	end

	assign res_valid = res_valid_q;
	assign next_pc   = res_pc_q;
	assign out_valid = res_ov_q;
	assign out_kind  = res_ok_q;
	assign out_value = res_oval_q;
	assign in_taken  = res_taken_q;
	assign halted    = res_halt_q;
	assign exit_code = res_exit_q;

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RDA)
		else $error("accepted item did not start the read step");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(halt_q))
		else $error("halt flag cleared without reset");

	a_iter_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && it_cnt_q != 3'd7) |=> state_q == S_ITER)
		else $error("iteration left before eight steps");

	a_rf_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> (state_q == S_CLEAR || state_q == S_WR1 || state_q == S_WR2))
		else $error("register write outside a write step");

	a_mem_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_MEM))
		else $error("memory write outside the memory step");
`endif

endmodule

>>> test/byte_machine_instruction_executor_tb.sv
module byte_machine_instruction_executor_tb;
	import bmie_pkg::*;

	// Item kind that the block accepts and answers without any effect
	localparam logic [1:0] ITEM_NONE = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] word;
		logic [7:0]  in_value;
		logic        in_present;
		logic [7:0]  addr;
		logic [7:0]  value;
	} machine_item_t;

	typedef struct packed {
		logic [7:0] next_pc;
		logic       out_valid;
		logic       out_kind;
		logic [7:0] out_value;
		logic       in_taken;
		logic       halted;
		logic [7:0] exit_code;
	} machine_result_t;

	logic        clk;
	logic        arst_n;
	logic        start_pc_we;
	logic [7:0]  start_pc;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  opcode;
	logic [15:0] instruction;
	logic [7:0]  in_value;
	logic        in_present;
	logic [7:0]  load_address;
	logic [7:0]  load_value;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [7:0]  next_pc;
	logic        out_valid;
	logic        out_kind;
	logic [7:0]  out_value;
	logic        in_taken;
	logic        halted;
	logic [7:0]  exit_code;

	// Predicted machine state
	logic [7:0] pred_regs [NUM_REGS];
	logic [7:0] pred_mem [DATA_DEPTH];
	logic [7:0] pred_pc;
	logic       pred_halt;
	logic [7:0] pred_exit;

	machine_result_t pending_results [$];
	int unsigned     mismatches = 0;
	logic            steady = 1'b0;

	byte_machine_instruction_executor DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_pc_we  (start_pc_we),
		.start_pc     (start_pc),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.instruction  (instruction),
		.in_value     (in_value),
		.in_present   (in_present),
		.load_address (load_address),
		.load_value   (load_value),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.next_pc      (next_pc),
		.out_valid    (out_valid),
		.out_kind     (out_kind),
		.out_value    (out_value),
		.in_taken     (in_taken),
		.halted       (halted),
		.exit_code    (exit_code)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end

	// Apply one item to the predicted state and return the beat it must produce
	function automatic machine_result_t machine_step(input machine_item_t it);
		machine_result_t r;
		op_t        op;
		logic [3:0] a, b, c, nx;
		logic [7:0] k, rb, rc, t, sum;
		logic [15:0] p;
		r = '0;
		if (it.kind == ITEM_LDREG) begin
			pred_regs[it.addr[3:0]] = it.value;
		end else if (it.kind == ITEM_LDMEM) begin
			pred_mem[it.addr] = it.value;
		end else if (it.kind == ITEM_EXEC && !pred_halt) begin
			op = op_t'(it.word[15:12]);
			a = it.word[11:8];
			b = it.word[7:4];
			c = it.word[3:0];
			k = it.word[7:0];
			nx = a + 4'd1;
			rb = pred_regs[b];
			rc = pred_regs[c];
			sum = rb + rc;
			pred_pc = pred_pc + 8'd1;
			case (op)
				OP_DIVPUSH: begin
					if (b != c) begin
						// divide by zero leaves the registers and memory alone
						if (rc != 8'd0) begin
							pred_regs[a] = rb / rc;
							pred_regs[nx] = rb % rc;
						end
					end else if (a != b) begin
						pred_regs[a] = pred_regs[a] - 8'd1;
						pred_mem[pred_regs[a]] = pred_regs[b];
					end else begin
						pred_exit = pred_regs[a];
						pred_halt = 1'b1;
					end
				end
				OP_POPRET: begin
					if (a != b && a != c) begin
						t = pred_pc;
						pred_pc = pred_mem[pred_regs[a]];
						pred_regs[a] = pred_regs[a] + rc + 8'd1;
						pred_regs[b] = t;
					end else if (a != b) begin
						pred_regs[b] = pred_mem[pred_regs[a]];
						pred_regs[a] = pred_regs[a] + 8'd1;
					end else begin
						t = pred_pc;
						pred_pc = rc;
						pred_regs[a] = t;
					end
				end
				OP_SLT_SHL: pred_regs[a] = (b != c) ? {7'd0, rb < rc} : {rb[6:0], 1'b0};
				OP_SUB_SHR: pred_regs[a] = (b != c) ? rb - rc : {1'b0, rb[7:1]};
				OP_LD_ADD: pred_regs[a] = (b <= c) ? pred_mem[sum] : sum;
				OP_ST_OR: begin
					if (b <= c) pred_mem[sum] = pred_regs[a];
					else pred_regs[a] = rb | rc;
				end
				OP_MUL_AND: begin
					if (b <= c) begin
						p = {8'd0, rb} * {8'd0, rc};
						pred_regs[nx] = p[15:8];
						pred_regs[a] = p[7:0];
					end else begin
						pred_regs[a] = rb & rc;
					end
				end
				OP_JIND_XOR: begin
					if (b <= c) begin
						t = pred_pc;
						sum = pred_regs[a] + rb;
						pred_pc = pred_mem[sum];
						pred_regs[a] = t;
					end else begin
						pred_regs[a] = rb ^ rc;
					end
				end
				OP_JZ: if (pred_regs[a] == 8'd0) pred_pc = k;
				OP_JNZ: if (pred_regs[a] != 8'd0) pred_pc = k;
				OP_JAL: begin
					pred_regs[a] = pred_pc;
					pred_pc = k;
				end
				OP_CALL: begin
					pred_regs[a] = pred_regs[a] - 8'd1;
					pred_mem[pred_regs[a]] = pred_pc;
					pred_pc = k;
				end
				OP_LDK: pred_regs[a] = pred_mem[k];
				OP_STK: pred_mem[k] = pred_regs[a];
				OP_LI: pred_regs[a] = k;
				default: begin
					if (k == SYS_READ_A || k == SYS_READ_B) begin
						if (it.in_present) begin
							pred_regs[nx] = 8'd1;
							pred_regs[a] = it.in_value;
							r.in_taken = 1'b1;
						end else begin
							pred_regs[nx] = 8'd0;
						end
					end else if (k == SYS_PRINT_NUM || k == SYS_PRINT_CHR) begin
						r.out_valid = 1'b1;
						r.out_kind = (k == SYS_PRINT_CHR);
						r.out_value = pred_regs[a];
					end
				end
			endcase
		end
		r.next_pc = pred_pc;
		r.halted = pred_halt;
		r.exit_code = pred_exit;
		return r;
	endfunction

	function automatic machine_item_t exec_word(input logic [15:0] word, input logic [7:0] ival,
			input logic ipres);
		machine_item_t it;
		it.kind = ITEM_EXEC;
		it.word = word;
		it.in_value = ival;
		it.in_present = ipres;
		it.addr = $urandom;
		it.value = $urandom;
		return it;
	endfunction

	function automatic machine_item_t load_item(input logic [1:0] kind, input logic [7:0] addr,
			input logic [7:0] value);
		machine_item_t it;
		it.kind = kind;
		it.word = $urandom;
		it.in_value = $urandom;
		it.in_present = $urandom;
		it.addr = addr;
		it.value = value;
		return it;
	endfunction

	// Random item: mostly instructions, some preloads, a few dead items; never a halt
	function automatic machine_item_t random_item();
		machine_item_t it;
		int unsigned   pick;
		pick = $urandom_range(99);
		it.word = $urandom;
		it.in_value = $urandom;
		it.in_present = $urandom;
		it.addr = $urandom;
		case ($urandom_range(7))
			0: it.value = 8'h00;
			1: it.value = 8'h01;
			2: it.value = 8'hFF;
			3: it.value = 8'h80;
			default: it.value = $urandom;
		endcase
		if (pick < 14) it.kind = ITEM_LDREG;
		else if (pick < 22) it.kind = ITEM_LDMEM;
		else if (pick < 24) it.kind = ITEM_NONE;
		else it.kind = ITEM_EXEC;
		// favor the b == c forms and the syscalls that do something
		if ($urandom_range(7) == 0) it.word[3:0] = it.word[7:4];
		if (it.word[15:12] == OP_SYS && $urandom_range(3) != 0)
			it.word[7:0] = $urandom_range(5);
		// keep the machine running
		if (it.word[15:12] == OP_DIVPUSH && it.word[11:8] == it.word[7:4] &&
				it.word[7:4] == it.word[3:0])
			it.word[3:0] = it.word[3:0] + 4'd1;
		return it;
	endfunction

	// Drive one item from a falling edge and hold it until accepted
	task automatic send_item(input machine_item_t it);
		if (!steady) begin
			while ($urandom_range(99) < 20) begin
				item_valid = 1'b0;
				@(negedge clk);
			end
		end
		opcode = it.kind;
		instruction = it.word;
		in_value = it.in_value;
		in_present = it.in_present;
		load_address = it.addr;
		load_value = it.value;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(machine_step(it));
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_start_pc(input logic [7:0] value);
		item_valid = 1'b0;
		start_pc_we = 1'b1;
		start_pc = value;
		@(posedge clk);
		pred_pc = value;
		@(negedge clk);
		start_pc_we = 1'b0;
	endtask

	// Field extremes, every major op, syscall numbers and wrapping addresses
	task automatic test_directed();
		logic [15:0] ops [16];
		ops = '{{OP_DIVPUSH, 12'h312}, {OP_DIVPUSH, 12'h511}, {OP_POPRET, 12'h565},
			{OP_SLT_SHL, 12'hB11}, {OP_SUB_SHR, 12'hC21}, {OP_LD_ADD, 12'hE11},
			{OP_ST_OR, 12'hF11}, {OP_MUL_AND, 12'h311}, {OP_JIND_XOR, 12'h321},
			{OP_JZ, 12'h0FF}, {OP_JNZ, 12'h1AB}, {OP_JAL, 12'h4C3},
			{OP_CALL, 12'h8EE}, {OP_LDK, 12'h9FF}, {OP_STK, 12'h1FF}, {OP_LI, 12'hF00}};
		// register preload uses only the low nibble of the address
		send_item(load_item(ITEM_LDREG, 8'hF1, 8'hFF));
		send_item(load_item(ITEM_LDMEM, 8'hFF, 8'h80));
		send_item(load_item(ITEM_NONE, 8'hFF, 8'hFF));
		foreach (ops[i]) send_item(exec_word(ops[i], $urandom, $urandom));
		send_item(exec_word({OP_SYS, 4'h2, SYS_READ_A}, 8'hFF, 1'b1));
		send_item(exec_word({OP_SYS, 4'h3, SYS_READ_B}, 8'h00, 1'b0));
		send_item(exec_word({OP_SYS, 4'h1, SYS_PRINT_NUM}, 8'h00, 1'b0));
		send_item(exec_word({OP_SYS, 4'hF, SYS_PRINT_CHR}, 8'h00, 1'b0));
		send_item(exec_word({OP_SYS, 4'h1, 8'd5}, 8'hFF, 1'b1));
		send_item(exec_word({OP_SYS, 4'h1, 8'd0}, 8'hFF, 1'b1));
	endtask

	task automatic test_random(input logic [7:0] pc, input int unsigned count,
			input logic no_idle);
		drain_results();
		write_start_pc(pc);
		steady = no_idle;
		repeat (count) send_item(random_item());
		steady = 1'b0;
	endtask

	// Halt, then executes are ignored while preloads and start_pc writes still land
	task automatic test_halt();
		send_item(load_item(ITEM_LDREG, 8'h07, 8'hA5));
		send_item(exec_word({OP_DIVPUSH, 12'h777}, 8'h00, 1'b0));
		repeat (4) send_item(exec_word($urandom, $urandom, $urandom));
		send_item(load_item(ITEM_LDREG, 8'h3C, 8'h5A));
		send_item(load_item(ITEM_LDMEM, 8'h00, 8'hC3));
		drain_results();
		write_start_pc(8'h5A);
		repeat (2) send_item(exec_word($urandom, $urandom, $urandom));
	endtask

	// Receiver: stall at random except during the steady stretch
	always @(negedge clk) res_stall <= !steady && ($urandom_range(99) < 20);

	// Compare each accepted result beat against the oldest prediction
	always @(posedge clk) begin : check_results
		machine_result_t want, got;
		logic            bad;
		if (arst_n && res_valid && !res_stall) begin
			got.next_pc = next_pc;
			got.out_valid = out_valid;
			got.out_kind = out_kind;
			got.out_value = out_value;
			got.in_taken = in_taken;
			got.halted = halted;
			got.exit_code = exit_code;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: pc=%h at %0t", got.next_pc, $realtime);
			end else begin
				want = pending_results.pop_front();
				bad = (got.next_pc !== want.next_pc) || (got.out_valid !== want.out_valid) ||
					(got.out_kind !== want.out_kind) || (got.out_value !== want.out_value) ||
					(got.in_taken !== want.in_taken) || (got.halted !== want.halted) ||
					(got.exit_code !== want.exit_code);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t: pc/ov/kind/val/taken/halt/exit", $realtime);
						$display("  expected %h %b %b %h %b %b %h", want.next_pc,
							want.out_valid, want.out_kind, want.out_value, want.in_taken,
							want.halted, want.exit_code);
						$display("  actual   %h %b %b %h %b %b %h", got.next_pc,
							got.out_valid, got.out_kind, got.out_value, got.in_taken,
							got.halted, got.exit_code);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start_pc_we = 1'b0;
		start_pc = 8'h00;
		item_valid = 1'b0;
		opcode = ITEM_EXEC;
		instruction = 16'h0000;
		in_value = 8'h00;
		in_present = 1'b0;
		load_address = 8'h00;
		load_value = 8'h00;
		foreach (pred_regs[i]) pred_regs[i] = 8'h00;
		foreach (pred_mem[i]) pred_mem[i] = 8'h00;
		pred_pc = 8'h00;
		pred_halt = 1'b0;
		pred_exit = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first fetch wraps the program counter
		write_start_pc(8'hFF);
		test_directed();
		test_random(8'h00, 520, 1'b0);
		test_random($urandom, 420, 1'b1);
		test_random(8'h80, 600, 1'b0);
		drain_results();
		test_halt();

		drain_results();
		repeat (20) @(posedge clk);
		mismatches += pending_results.size();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
